@@ hdl/pee_pkg.sv @@
package pee_pkg;

	localparam int StackDepth = 128;
	localparam int ValueWidth = 32;
	localparam int PtrWidth = $clog2(StackDepth);
	localparam int CntWidth = $clog2(StackDepth + 1);
	localparam int ShCntWidth = $clog2(ValueWidth + 1);

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [CntWidth-1:0] count_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_POW,
		OP_BAD
	} op_t;

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChStar  = 8'h2a;
	localparam logic [7:0] ChSlash = 8'h2f;
	localparam logic [7:0] ChCaret = 8'h5e;

	// datapath commands from the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_DIGIT,
		CMD_PUSH_NUM,
		CMD_POP_A,
		CMD_POP_B,
		CMD_EXEC,
		CMD_ITER,
		CMD_PUSH_RES,
		CMD_READ_TOP,
		CMD_EMIT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		op_t  op;
	} ctrl_t;

	typedef struct packed {
		logic in_number;
		logic iter_done;
		logic out_busy;
	} stat_t;

	function automatic op_t decode_op(input logic [7:0] c);
		op_t o;
		unique case (c)
			ChPlus:  o = OP_ADD;
			ChMinus: o = OP_SUB;
			ChStar:  o = OP_MUL;
			ChSlash: o = OP_DIV;
			ChCaret: o = OP_POW;
			default: o = OP_BAD;
		endcase
		return o;
	endfunction

endpackage

@@ hdl/pee_ctrl.sv @@
module pee_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          in_ch,
	input  logic                in_last,
	input  pee_pkg::stat_t      stat,
	output pee_pkg::ctrl_t      ctrl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSHNUM,
		S_POPA,
		S_POPB,
		S_EXEC,
		S_ITER,
		S_PUSHRES,
		S_ENDNUM,
		S_READ,
		S_EMIT
	} state_t;

	state_t state_q;
	logic [7:0] ch_q;
	logic last_q;
	pee_pkg::op_t op_q;
	logic take;
	logic is_digit;

	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && (state_q == S_IDLE);
	assign is_digit = (in_ch >= pee_pkg::ChZero) && (in_ch <= pee_pkg::ChNine);

	// command decode from state
	always_comb begin
		ctrl.op = op_q;
		ctrl.cmd = pee_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE:    ctrl.cmd = (take && is_digit) ? pee_pkg::CMD_DIGIT : pee_pkg::CMD_NONE;
			S_PUSHNUM, S_ENDNUM: ctrl.cmd = pee_pkg::CMD_PUSH_NUM;
			S_POPA:    ctrl.cmd = pee_pkg::CMD_POP_A;
			S_POPB:    ctrl.cmd = pee_pkg::CMD_POP_B;
			S_EXEC:    ctrl.cmd = pee_pkg::CMD_EXEC;
			S_ITER:    ctrl.cmd = pee_pkg::CMD_ITER;
			S_PUSHRES: ctrl.cmd = pee_pkg::CMD_PUSH_RES;
			S_READ:    ctrl.cmd = pee_pkg::CMD_READ_TOP;
			S_EMIT:    ctrl.cmd = stat.out_busy ? pee_pkg::CMD_NONE : pee_pkg::CMD_EMIT;
			default:   ctrl.cmd = pee_pkg::CMD_NONE;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= '0;
			last_q <= 1'b0;
			op_q <= pee_pkg::OP_ADD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						ch_q <= in_ch;
						last_q <= in_last;
						op_q <= pee_pkg::decode_op(in_ch);
						if (is_digit)
							state_q <= in_last ? S_ENDNUM : S_IDLE;
						else if (stat.in_number)
							state_q <= S_PUSHNUM;
						else if (in_ch != pee_pkg::ChSpace)
							state_q <= S_POPA;
						else
							state_q <= in_last ? S_READ : S_IDLE;
					end
				end
				S_PUSHNUM: begin
					if (ch_q != pee_pkg::ChSpace)
						state_q <= S_POPA;
					else
						state_q <= last_q ? S_READ : S_IDLE;
				end
				S_POPA:    state_q <= S_POPB;
				S_POPB:    state_q <= S_EXEC;
				S_EXEC:    state_q <= S_ITER;
				S_ITER:    if (stat.iter_done) state_q <= S_PUSHRES;
				S_PUSHRES: state_q <= last_q ? S_ENDNUM : S_IDLE;
				S_ENDNUM:  state_q <= S_READ;
				S_READ:    state_q <= S_EMIT;
				S_EMIT:    if (!stat.out_busy) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/pee_dp.sv @@
module pee_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          in_ch,
	input  pee_pkg::ctrl_t      ctrl,
	output pee_pkg::stat_t      stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  value,
	output logic [1:0]          status
);

	localparam int VW = pee_pkg::ValueWidth;

	pee_pkg::value_t stack_mem [pee_pkg::StackDepth];
	pee_pkg::value_t rd_q;
	pee_pkg::count_t count_q;
	pee_pkg::value_t num_q, weight_q;
	logic in_num_q;
	logic [1:0] err_q;
	pee_pkg::value_t a_q, b_q, res_q, rem_q, quo_q, base_q, exp_q;
	logic [pee_pkg::ShCntWidth-1:0] it_q;
	logic a_ok_q;
	logic neg_q;
	logic top_ok_q;

	logic empty, full;
	logic [pee_pkg::PtrWidth-1:0] top_idx, wr_idx;
	pee_pkg::value_t push_val;
	logic push_en;
	logic pop_en;
	logic [VW:0] trial;
	pee_pkg::value_t rem_sh;
	pee_pkg::value_t b_in, mag_a, mag_b;
	pee_pkg::value_t pow_neg;
	logic iter_done;
	pee_pkg::count_t count_d;
	logic [1:0] err_d;
	logic out_valid_d;

	assign empty = (count_q == '0);
	assign full = (count_q == pee_pkg::count_t'(pee_pkg::StackDepth));
	assign top_idx = pee_pkg::PtrWidth'(count_q - 1'b1);
	assign wr_idx = pee_pkg::PtrWidth'(count_q);
	assign push_en = (ctrl.cmd == pee_pkg::CMD_PUSH_NUM && in_num_q) ||
		(ctrl.cmd == pee_pkg::CMD_PUSH_RES);
	assign pop_en = (ctrl.cmd == pee_pkg::CMD_POP_A) || (ctrl.cmd == pee_pkg::CMD_POP_B);
	assign push_val = (ctrl.cmd == pee_pkg::CMD_PUSH_RES) ? res_q : num_q;

	// second operand lands from the stack read in the setup cycle
	assign b_in = a_ok_q ? rd_q : '0;
	assign mag_a = a_q[VW-1] ? (-a_q) : a_q;
	assign mag_b = b_in[VW-1] ? (-b_in) : b_in;

	// restoring divide step on remainder and quotient
	assign rem_sh = {rem_q[VW-2:0], quo_q[VW-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, base_q};

	assign iter_done = (ctrl.op == pee_pkg::OP_DIV) ? (it_q == '0) :
		((ctrl.op == pee_pkg::OP_POW) ? (exp_q == '0) : 1'b1);
	assign stat = '{in_number: in_num_q, iter_done: iter_done,
		out_busy: out_valid && out_stall};

	// power with a negative exponent
	always_comb begin
		if (a_q == pee_pkg::value_t'(1))
			pow_neg = pee_pkg::value_t'(1);
		else if (a_q == '1)
			pow_neg = b_in[0] ? '1 : pee_pkg::value_t'(1);
		else
			pow_neg = '0;
	end

	// stack count next value
	always_comb begin
		count_d = count_q;
		if (push_en && !full)
			count_d = count_q + 1'b1;
		else if (pop_en && !empty)
			count_d = count_q - 1'b1;
		else if (ctrl.cmd == pee_pkg::CMD_EMIT)
			count_d = '0;
	end

	// sticky status, first error of the expression wins
	always_comb begin
		err_d = err_q;
		if (err_q == pee_pkg::ST_OK) begin
			if (pop_en && empty)
				err_d = pee_pkg::ST_UNDERFLOW;
			else if (ctrl.cmd == pee_pkg::CMD_PUSH_RES && ctrl.op == pee_pkg::OP_DIV &&
				b_q == '0)
				err_d = pee_pkg::ST_DIVZERO;
			else if (push_en && full)
				err_d = pee_pkg::ST_OVERFLOW;
		end
		if (ctrl.cmd == pee_pkg::CMD_EMIT)
			err_d = pee_pkg::ST_OK;
	end

	// result valid holds until taken
	always_comb begin
		out_valid_d = out_valid && out_stall;
		if (ctrl.cmd == pee_pkg::CMD_EMIT)
			out_valid_d = 1'b1;
	end

	// stack memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (push_en && !full)
			stack_mem[wr_idx] <= push_val;
		rd_q <= stack_mem[top_idx];
	end

	// number builder, stack pointer, operand unit, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			num_q <= '0;
			weight_q <= pee_pkg::value_t'(1);
			in_num_q <= 1'b0;
			err_q <= pee_pkg::ST_OK;
			out_valid <= 1'b0;
			value <= '0;
			status <= '0;
			a_q <= '0;
			b_q <= '0;
			res_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			base_q <= '0;
			exp_q <= '0;
			it_q <= '0;
			a_ok_q <= 1'b0;
			neg_q <= 1'b0;
			top_ok_q <= 1'b0;
		end else begin
			count_q <= count_d;
			err_q <= err_d;
			out_valid <= out_valid_d;
			case (ctrl.cmd)
				pee_pkg::CMD_DIGIT: begin
					num_q <= num_q + pee_pkg::value_t'(in_ch[3:0]) * weight_q;
					weight_q <= (weight_q << 3) + (weight_q << 1);
					in_num_q <= 1'b1;
				end
				pee_pkg::CMD_PUSH_NUM: begin
					num_q <= '0;
					weight_q <= pee_pkg::value_t'(1);
					in_num_q <= 1'b0;
				end
				pee_pkg::CMD_POP_A: a_ok_q <= !empty;
				pee_pkg::CMD_POP_B: begin
					a_ok_q <= !empty;
					// read data for the prior pop lands now
					a_q <= a_ok_q ? rd_q : '0;
				end
				pee_pkg::CMD_EXEC: begin
					// operand setup for the iterative units
					b_q <= b_in;
					it_q <= pee_pkg::ShCntWidth'(VW);
					rem_q <= '0;
					quo_q <= mag_a;
					neg_q <= a_q[VW-1] ^ b_in[VW-1];
					if (ctrl.op == pee_pkg::OP_POW) begin
						base_q <= a_q;
						exp_q <= b_in[VW-1] ? '0 : b_in;
						res_q <= b_in[VW-1] ? pow_neg : pee_pkg::value_t'(1);
					end else begin
						base_q <= mag_b;
						exp_q <= '0;
					end
				end
				pee_pkg::CMD_ITER: begin
					unique case (ctrl.op)
						pee_pkg::OP_ADD: res_q <= a_q + b_q;
						pee_pkg::OP_SUB: res_q <= a_q - b_q;
						pee_pkg::OP_MUL: res_q <= a_q * b_q;
						pee_pkg::OP_DIV: begin
							if (it_q != '0) begin
								if (!trial[VW]) begin
									rem_q <= trial[VW-1:0];
									quo_q <= {quo_q[VW-2:0], 1'b1};
								end else begin
									rem_q <= rem_sh;
									quo_q <= {quo_q[VW-2:0], 1'b0};
								end
								it_q <= it_q - 1'b1;
							end else if (b_q == '0) begin
								res_q <= '0;
							end else begin
								res_q <= neg_q ? -quo_q : quo_q;
							end
						end
						pee_pkg::OP_POW: begin
							// square and multiply, one exponent bit a cycle
							if (exp_q != '0) begin
								if (exp_q[0])
									res_q <= res_q * base_q;
								base_q <= base_q * base_q;
								exp_q <= exp_q >> 1;
							end
						end
						default: res_q <= '1;
					endcase
				end
				pee_pkg::CMD_READ_TOP: top_ok_q <= !empty;
				pee_pkg::CMD_EMIT: begin
					value <= top_ok_q ? rd_q : '0;
					status <= (!top_ok_q && err_q == pee_pkg::ST_OK) ?
						pee_pkg::ST_UNDERFLOW : err_q;
					num_q <= '0;
					weight_q <= pee_pkg::value_t'(1);
					in_num_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/prefix_expression_evaluator_top.sv @@
// prefix expression evaluator, one character per request, one request in flight
// a digit is accumulated while idle; a space or operator ending a number pushes it first
// + - * and unknown operators pop two operands, set up, iterate and push the result
// divide iterates over the quotient bits, power over the exponent bits
// a last request then reads the stack top and emits, waiting while the output stalls
// arst_n clears the stack count, number builder, sticky status and output valid
module prefix_expression_evaluator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [1:0]         status
);

	pee_pkg::ctrl_t ctrl;
	pee_pkg::stat_t stat;

	pee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_ch(ch), .in_last(last), .stat(stat), .ctrl(ctrl)
	);

	pee_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_ch(ch), .ctrl(ctrl), .stat(stat),
		.out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status)
	);

	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
		else $error("result changed under stall");

	// no request taken while an operator iterates
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmd == pee_pkg::CMD_ITER |-> in_stall)
		else $error("request accepted during operator");

endmodule
